>>> rtl/utf8pc_pkg.sv
// Package for the UTF-8 printable checker: beat types, decode state and
// encoding limits. No dependencies.
`timescale 1ns / 1ps

package utf8pc_pkg;

  localparam logic [7:0]  LeadTwoLo   = 8'hc2;
  localparam logic [7:0]  LeadTwoHi   = 8'hdf;
  localparam logic [7:0]  LeadThreeLo = 8'he0;
  localparam logic [7:0]  LeadThreeHi = 8'hef;
  localparam logic [7:0]  LeadFourLo  = 8'hf0;
  localparam logic [7:0]  LeadFourHi  = 8'hf4;
  localparam logic [7:0]  AsciiDel    = 8'h7f;
  localparam logic [7:0]  AsciiNul    = 8'h00;
  localparam logic [7:0]  AsciiTab    = 8'h09;
  localparam logic [7:0]  AsciiLf     = 8'h0a;
  localparam logic [7:0]  AsciiCr     = 8'h0d;
  localparam logic [7:0]  AsciiSpace  = 8'h20;
  localparam logic [20:0] MinThree    = 21'h000800;
  localparam logic [20:0] MinFour     = 21'h010000;
  localparam logic [20:0] SurrLo      = 21'h00d800;
  localparam logic [20:0] SurrHi      = 21'h00dfff;
  localparam logic [20:0] MaxCode     = 21'h10ffff;

  localparam logic [1:0]  LenTwo      = 2'd1;
  localparam logic [1:0]  LenThree    = 2'd2;
  localparam logic [1:0]  LenFour     = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic well_formed;
    logic printable;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]  bytes_pending;
    logic [1:0]  sequence_length;
    logic [20:0] code_point;
    logic        seen_visible;
    logic        error_seen;
  } dec_state_t;

endpackage

>>> rtl/utf8_printable_checker.sv
// Top level of the UTF-8 printable checker: input register, decode step,
// result register. Depends on utf8pc_pkg and utf8pc_step.
`timescale 1ns / 1ps
//
//  channel | direction | payload      | handshake
//  --------+-----------+--------------+------------------------
//  in      | input     | in_beat_t    | in_valid_i / in_ready_o
//  out     | output    | out_beat_t   | out_valid_o / out_ready_i
//
//  One byte per cycle sustained while no final byte waits on a stalled output.
//  The rate is set by the single decode step between the input and result
//  registers, which updates the decode state once per byte.
//  Reset clears the decode state and both valid flags.
//  A verdict waiting on a stalled output holds back only a final byte.

module utf8_printable_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  utf8pc_pkg::in_beat_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output utf8pc_pkg::out_beat_t out_data_o
);

  logic                   s1_valid_q, s1_valid_d;
  utf8pc_pkg::in_beat_t   s1_q;
  utf8pc_pkg::dec_state_t state_q, state_d;
  logic                   out_valid_q, out_valid_d;
  utf8pc_pkg::out_beat_t  out_q;
  utf8pc_pkg::out_beat_t  verdict;
  logic                   s1_fire;
  logic                   in_fire;

  utf8pc_step u_step (
    .state_i  (state_q),
    .beat_i   (s1_q),
    .state_o  (state_d),
    .verdict_o(verdict)
  );

  assign s1_fire     = s1_valid_q && (!s1_q.last_byte || !out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_fire;
  assign in_fire     = in_valid_i && in_ready_o;
  assign s1_valid_d  = in_fire || (s1_valid_q && !s1_fire);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (s1_fire && s1_q.last_byte) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_data_i;
    end
    if (s1_fire && s1_q.last_byte) begin
      out_q <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_printable_wf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_q.printable || out_q.well_formed))
    else $error("printable verdict without well_formed");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_q.last_byte) |=> (state_q == '0))
    else $error("decode state not cleared after final beat");

  a_pending_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.bytes_pending <= state_q.sequence_length)
    else $error("pending count exceeds sequence length");

  a_stall_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && s1_q.last_byte && out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked final beat");

endmodule

>>> rtl/utf8pc_step.sv
// Per-byte decode step for the UTF-8 printable checker: next state and
// verdict from the current state and one byte. Depends on utf8pc_pkg.
`timescale 1ns / 1ps

module utf8pc_step (
  input  utf8pc_pkg::dec_state_t state_i,
  input  utf8pc_pkg::in_beat_t   beat_i,
  output utf8pc_pkg::dec_state_t state_o,
  output utf8pc_pkg::out_beat_t  verdict_o
);

  utf8pc_pkg::dec_state_t nxt;
  logic [7:0]             b;
  logic [20:0]            cp_shift;
  logic                   ws;
  logic                   ok;

  assign b        = beat_i.data_byte;
  assign cp_shift = {state_i.code_point[14:0], b[5:0]};
  assign ws       = (b == utf8pc_pkg::AsciiSpace) || (b == utf8pc_pkg::AsciiTab) ||
                    (b == utf8pc_pkg::AsciiLf) || (b == utf8pc_pkg::AsciiCr);

  always_comb begin
    nxt = state_i;
    if (!state_i.error_seen) begin
      if (state_i.bytes_pending != 2'd0) begin
        if (b[7:6] != 2'b10) begin
          nxt.error_seen = 1'b1;
        end else begin
          nxt.code_point    = cp_shift;
          nxt.bytes_pending = state_i.bytes_pending - 2'd1;
          if (state_i.bytes_pending == 2'd1) begin
            if ((state_i.sequence_length == utf8pc_pkg::LenThree &&
                 cp_shift < utf8pc_pkg::MinThree) ||
                (state_i.sequence_length == utf8pc_pkg::LenFour &&
                 cp_shift < utf8pc_pkg::MinFour) ||
                (cp_shift >= utf8pc_pkg::SurrLo && cp_shift <= utf8pc_pkg::SurrHi) ||
                cp_shift > utf8pc_pkg::MaxCode) begin
              nxt.error_seen = 1'b1;
            end else begin
              nxt.seen_visible = 1'b1;
            end
          end
        end
      end else if (!b[7]) begin
        if (b == utf8pc_pkg::AsciiNul || b == utf8pc_pkg::AsciiDel ||
            (b < utf8pc_pkg::AsciiSpace && !ws)) begin
          nxt.error_seen = 1'b1;
        end else if (!ws) begin
          nxt.seen_visible = 1'b1;
        end
      end else if (b >= utf8pc_pkg::LeadTwoLo && b <= utf8pc_pkg::LeadTwoHi) begin
        nxt.code_point      = {16'd0, b[4:0]};
        nxt.sequence_length = utf8pc_pkg::LenTwo;
        nxt.bytes_pending   = utf8pc_pkg::LenTwo;
      end else if (b >= utf8pc_pkg::LeadThreeLo && b <= utf8pc_pkg::LeadThreeHi) begin
        nxt.code_point      = {17'd0, b[3:0]};
        nxt.sequence_length = utf8pc_pkg::LenThree;
        nxt.bytes_pending   = utf8pc_pkg::LenThree;
      end else if (b >= utf8pc_pkg::LeadFourLo && b <= utf8pc_pkg::LeadFourHi) begin
        nxt.code_point      = {18'd0, b[2:0]};
        nxt.sequence_length = utf8pc_pkg::LenFour;
        nxt.bytes_pending   = utf8pc_pkg::LenFour;
      end else begin
        nxt.error_seen = 1'b1;
      end
    end
  end

  assign ok                    = !nxt.error_seen && (nxt.bytes_pending == 2'd0);
  assign verdict_o.well_formed = ok;
  assign verdict_o.printable   = ok && nxt.seen_visible;
  assign state_o               = beat_i.last_byte ? '0 : nxt;

endmodule
